// File: design/gmt_pkg.sv
// Shared types and constants for the group member table with aging.
package gmt_pkg;

  localparam int ID_W   = 32;
  localparam int OP_W   = 2;
  localparam int TO_W   = 16;
  localparam int LIVE_W = 7;
  localparam int STAT_W = 2;

  localparam logic [TO_W-1:0] TO_RESET = 16'd30;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_GROUP  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_MEMBER = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  // Controller to datapath.
  typedef struct packed {
    logic accept;   // operation taken from the input ports
    logic rd_en;    // advance the table scan
    logic fin;      // first scan finished, resolve the operation
    logic restart;  // begin the member emission scan of a get
  } gmt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic need_pass2;
  } gmt_sts_t;

endpackage

// File: design/gmt_ctrl.sv
// Sequencer for the table scans of one operation.
module gmt_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gmt_pkg::OP_W-1:0]   in_operation,
  input  gmt_pkg::gmt_sts_t          sts,
  output gmt_pkg::gmt_cmd_t          cmd,
  output logic                       busy
);
  import gmt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN1 = 2'd1;
  localparam logic [1:0] S_FIN1  = 2'd2;
  localparam logic [1:0] S_SCAN2 = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.fin     = 1'b0;
    cmd.restart = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          // a tick completes in the datapath, so the sequencer stays idle
          if (in_operation != OP_TICK) state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_done) state_nxt = S_FIN1;
      end
      S_FIN1: begin
        cmd.fin = 1'b1;
        if (sts.need_pass2) begin
          cmd.restart = 1'b1;
          state_nxt   = S_SCAN2;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN2: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: design/gmt_dpath.sv
// Table storage, scan compare, aging and result registers.
module gmt_dpath #(
  parameter int NUM_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gmt_pkg::gmt_cmd_t             cmd,
  output gmt_pkg::gmt_sts_t             sts,
  input  logic [gmt_pkg::OP_W-1:0]      in_operation,
  input  logic [gmt_pkg::ID_W-1:0]      in_member_id,
  input  logic [gmt_pkg::ID_W-1:0]      in_group_id,
  input  logic                          cfg_valid,
  input  logic [gmt_pkg::TO_W-1:0]      cfg_data,
  output logic                          cfg_ready,
  output logic                          out_strobe,
  output logic [gmt_pkg::ID_W-1:0]      out_member_out,
  output logic                          out_member_valid,
  output logic [gmt_pkg::LIVE_W-1:0]    out_live_count,
  output logic [gmt_pkg::STAT_W-1:0]    out_status,
  output logic                          out_last
);
  import gmt_pkg::*;

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_ENTRIES);

  // table payload
  logic [ID_W-1:0] grp_mem  [NUM_ENTRIES];
  logic [ID_W-1:0] mbr_mem  [NUM_ENTRIES];
  logic [ID_W-1:0] time_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_r;

  logic [ID_W-1:0] now_r;
  logic [TO_W-1:0] timeout_r;

  logic [OP_W-1:0] op_r;
  logic [ID_W-1:0] grp_r;
  logic [ID_W-1:0] mbr_r;

  logic [CW-1:0]   rd_idx_r;
  logic            cmp_en_r;
  logic [IW-1:0]   cmp_idx_r;
  logic [ID_W-1:0] q_grp_r;
  logic [ID_W-1:0] q_mbr_r;
  logic [ID_W-1:0] q_time_r;

  logic            pass2_r;
  logic            found_r;
  logic            hit_r;
  logic            free_found_r;
  logic [IW-1:0]   free_idx_r;
  logic [CW-1:0]   live_cnt_r;
  logic [CW-1:0]   emit_cnt_r;

  logic                out_strobe_r;
  logic [ID_W-1:0]     out_member_r;
  logic                out_valid_r;
  logic [LIVE_W-1:0]   out_count_r;
  logic [STAT_W-1:0]   out_status_r;
  logic                out_last_r;

  logic            rd_fire;
  logic            tick_go;
  logic            c_valid;
  logic            c_grp;
  logic            c_pair;
  logic [ID_W-1:0] c_age;
  logic            c_live;
  logic            p1;
  logic            p2;
  logic            renew;
  logic            take_free;
  logic            get_live;
  logic            get_exp;
  logic            rm_hit;
  logic            emit;
  logic            add_new;
  logic            fin_out;
  logic            we_time;
  logic [IW-1:0]   wr_addr;
  logic [STAT_W-1:0] fin_status;

  assign rd_fire = cmd.rd_en && (rd_idx_r != LAST_IDX);
  assign tick_go = cmd.accept && (in_operation == OP_TICK);

  assign c_valid = valid_r[cmp_idx_r];
  assign c_grp   = c_valid && (q_grp_r == grp_r);
  assign c_pair  = c_grp && (q_mbr_r == mbr_r);
  assign c_age   = now_r - q_time_r;
  assign c_live  = c_age < ID_W'(timeout_r);

  assign p1 = cmp_en_r && !pass2_r;
  assign p2 = cmp_en_r && pass2_r;

  assign renew     = p1 && (op_r == OP_INSERT) && c_pair;
  assign take_free = p1 && (op_r == OP_INSERT) && !c_valid && !free_found_r;
  assign get_live  = p1 && (op_r == OP_GET) && c_grp && c_live;
  assign get_exp   = p1 && (op_r == OP_GET) && c_grp && !c_live;
  assign rm_hit    = p1 && (op_r == OP_REMOVE) && c_pair && !hit_r;
  assign emit      = p2 && c_grp;
  assign add_new   = cmd.fin && (op_r == OP_INSERT) && !hit_r && free_found_r;

  assign sts.scan_done  = (rd_idx_r == LAST_IDX) && !cmp_en_r;
  assign sts.need_pass2 = (op_r == OP_GET) && found_r && (live_cnt_r != '0);
  assign fin_out        = cmd.fin && !sts.need_pass2;

  assign we_time = renew || add_new;
  assign wr_addr = add_new ? free_idx_r : cmp_idx_r;

  always_comb begin
    unique case (op_r)
      OP_INSERT: fin_status = (hit_r || free_found_r) ? STAT_DONE : STAT_FULL;
      OP_GET:    fin_status = found_r ? STAT_DONE : STAT_NO_GROUP;
      OP_REMOVE: fin_status = hit_r ? STAT_DONE :
                              (found_r ? STAT_NO_MEMBER : STAT_NO_GROUP);
      default:   fin_status = STAT_DONE;
    endcase
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_time) time_mem[wr_addr] <= now_r;
    if (add_new) begin
      grp_mem[wr_addr] <= grp_r;
      mbr_mem[wr_addr] <= mbr_r;
    end
    if (rd_fire) begin
      q_grp_r  <= grp_mem[rd_idx_r[IW-1:0]];
      q_mbr_r  <= mbr_mem[rd_idx_r[IW-1:0]];
      q_time_r <= time_mem[rd_idx_r[IW-1:0]];
      cmp_idx_r <= rd_idx_r[IW-1:0];
    end
  end

  // operation payload and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      grp_r <= in_group_id;
      mbr_r <= in_member_id;
    end
    if (take_free) free_idx_r <= cmp_idx_r;
    priority if (tick_go) begin
      out_member_r <= '0;
      out_valid_r  <= 1'b0;
      out_count_r  <= '0;
      out_status_r <= STAT_DONE;
      out_last_r   <= 1'b1;
    end else if (emit) begin
      out_member_r <= q_mbr_r;
      out_valid_r  <= 1'b1;
      out_count_r  <= LIVE_W'(live_cnt_r);
      out_status_r <= STAT_DONE;
      out_last_r   <= ((emit_cnt_r + CW'(1)) == live_cnt_r);
    end else if (fin_out) begin
      out_member_r <= '0;
      out_valid_r  <= 1'b0;
      out_count_r  <= '0;
      out_status_r <= fin_status;
      out_last_r   <= 1'b1;
    end else begin
      out_member_r <= out_member_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      now_r        <= '0;
      timeout_r    <= TO_RESET;
      rd_idx_r     <= '0;
      cmp_en_r     <= 1'b0;
      pass2_r      <= 1'b0;
      found_r      <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      live_cnt_r   <= '0;
      emit_cnt_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_valid) timeout_r <= cfg_data;
      if (tick_go) now_r <= now_r + ID_W'(1);

      cmp_en_r <= rd_fire;
      if (cmd.accept || cmd.restart) begin
        rd_idx_r <= '0;
      end else if (rd_fire) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end

      if (cmd.accept) begin
        pass2_r      <= 1'b0;
        found_r      <= 1'b0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
        live_cnt_r   <= '0;
        emit_cnt_r   <= '0;
      end else begin
        if (cmd.restart) begin
          pass2_r    <= 1'b1;
          emit_cnt_r <= '0;
        end else if (emit) begin
          emit_cnt_r <= emit_cnt_r + CW'(1);
        end
        if (p1 && c_grp) found_r <= 1'b1;
        if (renew || rm_hit) hit_r <= 1'b1;
        if (take_free) free_found_r <= 1'b1;
        if (get_live) live_cnt_r <= live_cnt_r + CW'(1);
      end

      // drop expired or removed pairs, claim the free slot on a new insert
      if (get_exp || rm_hit) valid_r[cmp_idx_r] <= 1'b0;
      if (add_new) valid_r[free_idx_r] <= 1'b1;

      out_strobe_r <= tick_go || emit || fin_out;
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_strobe       = out_strobe_r;
  assign out_member_out   = out_member_r;
  assign out_member_valid = out_valid_r;
  assign out_live_count   = out_count_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

endmodule

// File: design/group_member_table_aging_unit.sv
// Group member table with aging: top level joining sequencer and datapath.
// A tick's result is registered and appears in the cycle after start; busy
// stays low. Insert and remove scan the whole table through its single read
// port, and the one result appears as busy falls. Get first scans to count
// live members and erase the expired ones; only if the group has live members
// does it scan again to emit each live member on a cycle of its own. Results
// are registered and shown for one cycle with out_strobe; the receiver cannot
// stall, so out_last marks the end of each operation. Reset empties the table
// at once, no clearing pass is needed. The user must write the timeout
// register through cfg_valid/cfg_data only while the unit is idle; the block
// does not enforce this. cfg_ready is always high.
module group_member_table_aging_unit #(
  parameter int NUM_ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gmt_pkg::OP_W-1:0]      in_operation,
  input  logic [gmt_pkg::ID_W-1:0]      in_member_id,
  input  logic [gmt_pkg::ID_W-1:0]      in_group_id,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gmt_pkg::TO_W-1:0]      cfg_data,
  output logic                          out_strobe,
  output logic [gmt_pkg::ID_W-1:0]      out_member_out,
  output logic                          out_member_valid,
  output logic [gmt_pkg::LIVE_W-1:0]    out_live_count,
  output logic [gmt_pkg::STAT_W-1:0]    out_status,
  output logic                          out_last
);
  import gmt_pkg::*;

  gmt_cmd_t cmd;
  gmt_sts_t sts;

  gmt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  gmt_dpath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_member_id     (in_member_id),
    .in_group_id      (in_group_id),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .cfg_ready        (cfg_ready),
    .out_strobe       (out_strobe),
    .out_member_out   (out_member_out),
    .out_member_valid (out_member_valid),
    .out_live_count   (out_live_count),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

// File: tb/tb_group_member_table_aging_unit.sv
// Testbench for the group member table with aging, checked against a predicted table.
module tb_group_member_table_aging_unit;
  import gmt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;

  typedef enum logic {
    ACT_OP,
    ACT_TIMEOUT
  } action_kind_t;

  typedef struct {
    action_kind_t      kind;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   member;
    logic [ID_W-1:0]   group;
    logic [TO_W-1:0]   timeout;
    int unsigned       gap_pct;
  } table_action_t;

  typedef struct packed {
    logic [ID_W-1:0]   member;
    logic              mvalid;
    logic [LIVE_W-1:0] count;
    logic [STAT_W-1:0] status;
    logic              last;
  } member_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation = OP_TICK;
  logic [ID_W-1:0]   in_member_id = '0;
  logic [ID_W-1:0]   in_group_id = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TO_W-1:0]   cfg_data = '0;
  logic              out_strobe;
  logic [ID_W-1:0]   out_member_out;
  logic              out_member_valid;
  logic [LIVE_W-1:0] out_live_count;
  logic [STAT_W-1:0] out_status;
  logic              out_last;

  table_action_t  op_plan[$];
  member_report_t expected_reports[$];
  int unsigned    reports_due = 0;
  int unsigned    reports_seen = 0;
  int unsigned    fail_cnt = 0;
  int unsigned    gap_pct = 0;

  // Predicted table contents
  logic            model_valid [TABLE_DEPTH] = '{default: 1'b0};
  logic [ID_W-1:0] model_group [TABLE_DEPTH];
  logic [ID_W-1:0] model_member [TABLE_DEPTH];
  logic [ID_W-1:0] model_stamp [TABLE_DEPTH];
  logic [ID_W-1:0] model_now = '0;
  logic [TO_W-1:0] model_timeout = TO_RESET;

  group_member_table_aging_unit #(
    .NUM_ENTRIES(TABLE_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_member_id     (in_member_id),
    .in_group_id      (in_group_id),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_member_out   (out_member_out),
    .out_member_valid (out_member_valid),
    .out_live_count   (out_live_count),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_report(logic [ID_W-1:0] member, logic mvalid,
                                      logic [LIVE_W-1:0] count, logic [STAT_W-1:0] status,
                                      logic last);
    member_report_t r;
    r.member = member;
    r.mvalid = mvalid;
    r.count  = count;
    r.status = status;
    r.last   = last;
    expected_reports = {expected_reports, r};
  endfunction

  function automatic bit entry_live(int idx);
    logic [ID_W-1:0] age;
    age = model_now - model_stamp[idx];
    return age < {16'd0, model_timeout};
  endfunction

  // Apply one operation to the predicted table; return the number of results it yields.
  function automatic int unsigned predict_table_op(logic [OP_W-1:0] op,
                                                   logic [ID_W-1:0] member,
                                                   logic [ID_W-1:0] group);
    int          free_slot;
    bit          found;
    int unsigned live;
    int unsigned k;
    free_slot = -1;
    found = 1'b0;
    live = 0;
    k = 0;
    case (op)
      OP_TICK: begin
        model_now = model_now + 1;
        push_report('0, 1'b0, '0, STAT_DONE, 1'b1);
        return 1;
      end
      OP_INSERT: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (model_valid[i]) begin
            if (model_group[i] == group && model_member[i] == member) begin
              model_stamp[i] = model_now;
              push_report('0, 1'b0, '0, STAT_DONE, 1'b1);
              return 1;
            end
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (free_slot < 0) begin
          push_report('0, 1'b0, '0, STAT_FULL, 1'b1);
          return 1;
        end
        model_valid[free_slot]  = 1'b1;
        model_group[free_slot]  = group;
        model_member[free_slot] = member;
        model_stamp[free_slot]  = model_now;
        push_report('0, 1'b0, '0, STAT_DONE, 1'b1);
        return 1;
      end
      OP_GET: begin
        // Count live members and drop the expired ones of this group
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (model_valid[i] && model_group[i] == group) begin
            found = 1'b1;
            if (entry_live(i)) live++;
            else model_valid[i] = 1'b0;
          end
        end
        if (!found) begin
          push_report('0, 1'b0, '0, STAT_NO_GROUP, 1'b1);
          return 1;
        end
        if (live == 0) begin
          push_report('0, 1'b0, '0, STAT_DONE, 1'b1);
          return 1;
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (model_valid[i] && model_group[i] == group) begin
            k++;
            push_report(model_member[i], 1'b1, LIVE_W'(live), STAT_DONE, k == live);
          end
        end
        return k;
      end
      default: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (model_valid[i] && model_group[i] == group) begin
            found = 1'b1;
            if (model_member[i] == member) begin
              model_valid[i] = 1'b0;
              push_report('0, 1'b0, '0, STAT_DONE, 1'b1);
              return 1;
            end
          end
        end
        push_report('0, 1'b0, '0, found ? STAT_NO_MEMBER : STAT_NO_GROUP, 1'b1);
        return 1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [ID_W-1:0] want,
                                      logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic void plan_op(logic [OP_W-1:0] op, logic [ID_W-1:0] member,
                                  logic [ID_W-1:0] group);
    table_action_t a;
    a.kind    = ACT_OP;
    a.op      = op;
    a.member  = member;
    a.group   = group;
    a.timeout = '0;
    a.gap_pct = gap_pct;
    op_plan = {op_plan, a};
  endfunction

  function automatic void plan_timeout(logic [TO_W-1:0] value);
    table_action_t a;
    a.kind    = ACT_TIMEOUT;
    a.op      = OP_TICK;
    a.member  = '0;
    a.group   = '0;
    a.timeout = value;
    a.gap_pct = 0;
    op_plan = {op_plan, a};
  endfunction

  // Present planned operations; write the timeout only once every result is back.
  always @(posedge clk) begin : drive_proc
    logic          next_start;
    logic          next_cfg;
    table_action_t head;
    next_start = start;
    next_cfg   = cfg_valid;
    if (!rst_n) begin
      next_start = 1'b0;
      next_cfg   = 1'b0;
    end else begin
      if (start && !busy) next_start = 1'b0;
      if (cfg_valid && cfg_ready) next_cfg = 1'b0;
      if (!next_start && !next_cfg && op_plan.size() != 0) begin
        head = op_plan[0];
        if (head.kind == ACT_TIMEOUT) begin
          if (!start && !cfg_valid && !busy && reports_due == reports_seen) begin
            void'(op_plan.pop_front());
            cfg_data <= head.timeout;
            next_cfg = 1'b1;
          end
        end else if ($urandom_range(99) >= head.gap_pct) begin
          void'(op_plan.pop_front());
          in_operation <= head.op;
          in_member_id <= head.member;
          in_group_id  <= head.group;
          next_start = 1'b1;
        end
      end
    end
    start     <= next_start;
    cfg_valid <= next_cfg;
  end

  // Check results against the oldest prediction, then predict what transferred now.
  always @(posedge clk) begin : check_proc
    member_report_t want;
    int unsigned    n;
    if (rst_n) begin
      if (out_strobe) begin
        reports_seen <= reports_seen + 1;
        if (expected_reports.size() == 0) begin
          $error("unexpected result: member_out %0h status %0d last %0d",
                 out_member_out, out_status, out_last);
          fail_cnt++;
        end else begin
          want = expected_reports.pop_front();
          check_field("member_out", want.member, out_member_out);
          check_field("member_valid", want.mvalid, out_member_valid);
          check_field("live_count", want.count, out_live_count);
          check_field("status", want.status, out_status);
          check_field("last", want.last, out_last);
        end
      end
      if (start && !busy) begin
        n = predict_table_op(in_operation, in_member_id, in_group_id);
        reports_due <= reports_due + n;
      end
      if (cfg_valid && cfg_ready) model_timeout = cfg_data;
    end
  end

  initial begin
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] member;
    logic [ID_W-1:0] group;
    int unsigned     r;
    int unsigned     phase_gaps [4];

    phase_gaps = '{78, 0, 7, 78};

    // Directed: empty table, extremes of ids, renew, expiry, zero and one timeouts
    gap_pct = 0;
    plan_op(OP_GET, '0, '0);
    plan_op(OP_REMOVE, '0, '0);
    plan_op(OP_TICK, '0, '0);
    plan_op(OP_INSERT, '0, '0);
    plan_op(OP_INSERT, '1, '0);
    plan_op(OP_INSERT, 32'h5A5A_5A5A, '1);
    plan_op(OP_INSERT, '0, '0);
    plan_op(OP_GET, '0, '0);
    plan_op(OP_REMOVE, 32'h0001_2345, '0);
    plan_op(OP_REMOVE, 32'h5A5A_5A5A, '1);
    plan_op(OP_GET, '0, '1);
    plan_timeout(16'd1);
    plan_op(OP_TICK, '0, '0);
    plan_op(OP_INSERT, 32'd7, '0);
    plan_op(OP_GET, '0, '0);
    plan_op(OP_TICK, '0, '0);
    plan_op(OP_GET, '0, '0);
    plan_timeout(16'd0);
    plan_op(OP_INSERT, 32'd3, 32'd3);
    plan_op(OP_GET, '0, 32'd3);
    plan_op(OP_REMOVE, 32'd3, 32'd3);
    plan_op(OP_INSERT, 32'd4, 32'd4);
    plan_op(OP_REMOVE, 32'd4, 32'd4);
    plan_timeout(16'hFFFF);

    // Fill one group past capacity, read it whole, then let it all expire
    for (int i = 0; i < TABLE_DEPTH + 2; i++) plan_op(OP_INSERT, 32'h8000_0000 + i, 32'h100);
    plan_op(OP_GET, '0, 32'h100);
    plan_op(OP_INSERT, 32'h8000_0005, 32'h100);
    plan_op(OP_REMOVE, 32'h8000_0003, 32'h100);
    plan_op(OP_INSERT, 32'h7FFF_FFFF, 32'h100);
    plan_timeout(16'd1);
    plan_op(OP_TICK, '0, '0);
    plan_op(OP_GET, '0, 32'h100);
    plan_op(OP_GET, '0, 32'h100);

    // Random phases over a small pool of ids so that pairs meet again
    foreach (phase_gaps[p]) begin
      gap_pct = phase_gaps[p];
      plan_timeout((p == 1) ? 16'd30 : 16'($urandom_range(6, 2)));
      for (int i = 0; i < 55; i++) begin
        r      = $urandom_range(99);
        group  = ($urandom_range(9) == 0) ? $urandom() : 32'h10 + $urandom_range(5);
        member = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(9));
        if (r < 35) op = OP_INSERT;
        else if (r < 60) op = OP_GET;
        else if (r < 80) op = OP_REMOVE;
        else op = OP_TICK;
        plan_op(op, member, group);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (op_plan.size() != 0 || start || cfg_valid || busy || reports_due != reports_seen);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && expected_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_reports.size() != 0)
        $error("%0d expected results never arrived", expected_reports.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout waiting for the table to finish");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
